[sv/bfa_pkg.sv]
package bfa_pkg;

    // Request codes.
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_FREE    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_RESERVE = 3'd3;
    localparam logic [2:0] REQ_MARKALL = 3'd4;

    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Controller states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WAIT,
        ST_ACT,
        ST_MARK,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic wr_set;
        logic wr_clr;
        logic wr_fill;
        logic fill_next;
        logic step;
        logic cnt_up;
        logic cnt_dn;
        logic cnt_load;
        logic found;
        logic oom;
        logic res_load;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic [2:0] req;
        logic       in_range;
        logic       more;
        logic       bit_val;
        logic       fill_done;
    } t_stat;

endpackage

[sv/bfa_ram.sv]
module bfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/bfa_ctrl.sv]
module bfa_ctrl import bfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_fill   = 1'b1;
                o_cmd.fill_next = 1'b1;
                if (i_stat.fill_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RD;
                end
            end
            ST_RD: begin
                priority if (i_stat.req == REQ_MARKALL) begin
                    n_state = ST_MARK;
                end else if (i_stat.req == REQ_FREE || i_stat.req == REQ_RELEASE
                             || i_stat.req == REQ_RESERVE || i_stat.req == REQ_ALLOC) begin
                    if (i_stat.in_range && i_stat.more) begin
                        n_state = ST_WAIT;
                    end else begin
                        o_cmd.oom = (i_stat.req == REQ_ALLOC);
                        n_state   = ST_OUT;
                        o_cmd.res_load = 1'b1;
                    end
                end else begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_WAIT: begin
                n_state = ST_ACT;
            end
            ST_ACT: begin
                unique case (i_stat.req)
                    REQ_ALLOC: begin
                        if (!i_stat.bit_val) begin
                            o_cmd.wr_set   = 1'b1;
                            o_cmd.cnt_up   = 1'b1;
                            o_cmd.found    = 1'b1;
                            o_cmd.res_load = 1'b1;
                            n_state        = ST_OUT;
                        end else begin
                            o_cmd.step = 1'b1;
                            n_state    = ST_RD;
                        end
                    end
                    REQ_FREE: begin
                        if (i_stat.bit_val) begin
                            o_cmd.wr_clr = 1'b1;
                            o_cmd.cnt_dn = 1'b1;
                        end
                        o_cmd.res_load = 1'b1;
                        n_state        = ST_OUT;
                    end
                    REQ_RELEASE: begin
                        o_cmd.wr_clr = 1'b1;
                        o_cmd.cnt_dn = 1'b1;
                        o_cmd.step   = 1'b1;
                        n_state      = ST_RD;
                    end
                    default: begin
                        if (!i_stat.bit_val) begin
                            o_cmd.wr_set = 1'b1;
                            o_cmd.cnt_up = 1'b1;
                        end
                        o_cmd.step = 1'b1;
                        n_state    = ST_RD;
                    end
                endcase
            end
            ST_MARK: begin
                o_cmd.wr_fill   = 1'b1;
                o_cmd.fill_next = 1'b1;
                if (i_stat.fill_done) begin
                    o_cmd.cnt_load = 1'b1;
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_OUT;
                end
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // A word is never offered while a request is being taken.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(o_ready && o_valid))
        else $error("ready and valid together");
    // Memory write commands never collide.
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr_set, o_cmd.wr_clr, o_cmd.wr_fill}))
        else $error("conflicting writes");
    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped");
`endif

endmodule

[sv/bfa_dp.sv]
module bfa_dp import bfa_pkg::*; #(
    parameter int MAX_FRAMES  = 32768,
    parameter int FRAME_SHIFT = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic [2:0]  i_req,
    input  logic [31:0] i_addr,
    input  logic [31:0] i_len,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [26:0] o_frame_address,
    output logic        o_oom,
    output logic [27:0] o_used,
    output logic [27:0] o_free,
    output logic [27:0] o_total
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int LIM_W = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam logic [LIM_W-1:0] MAXF = LIM_W'(MAX_FRAMES);
    localparam logic [LIM_W-1:0] RST_CNT = (MAXF < LIM_W'(32768)) ? MAXF : LIM_W'(32768);

    logic [15:0]        r_cfg;
    logic [2:0]         r_req;
    logic [31:0]        r_cur;
    logic [32:0]        r_left;
    logic [COUNT_W-1:0] r_cnt;
    logic [AW-1:0]      r_fill;
    logic [26:0]        r_fa;
    logic               r_oom;
    logic [LIM_W-1:0]   w_lim;
    logic [LIM_W-1:0]   w_alim;
    logic [LIM_W-1:0]   w_cnt_ext;
    logic               w_fill_last;
    logic               w_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic               w_wdata;
    logic [63:0]        w_faddr;
    logic [63:0]        w_used;
    logic [63:0]        w_free;
    logic [63:0]        w_total;

    assign w_lim     = (LIM_W'(r_cfg) < MAXF) ? LIM_W'(r_cfg) : MAXF;
    assign w_alim    = {w_lim[LIM_W-1:3], 3'b000};
    assign w_cnt_ext = LIM_W'(r_cnt);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 16'd32768;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Request registers: current frame and frames left to walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_cur <= (i_req == REQ_ALLOC) ? 32'd0 : (i_addr >> FRAME_SHIFT);
            unique case (i_req)
                REQ_RELEASE: r_left <= 33'(i_len >> FRAME_SHIFT);
                REQ_RESERVE: r_left <= (33'(i_len) + (33'd1 << FRAME_SHIFT) - 33'd1)
                                       >> FRAME_SHIFT;
                default:     r_left <= 33'd1;
            endcase
        end else if (i_cmd.step) begin
            r_cur <= r_cur + 32'd1;
            if (r_req != REQ_ALLOC) begin
                r_left <= r_left - 33'd1;
            end
        end
    end

    // Used-frame counter, saturating.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= COUNT_W'(RST_CNT);
        end else if (i_cmd.cnt_load) begin
            r_cnt <= COUNT_W'(w_lim);
        end else if (i_cmd.cnt_up && r_cnt != COUNT_MAX) begin
            r_cnt <= r_cnt + COUNT_W'(1);
        end else if (i_cmd.cnt_dn && r_cnt != '0) begin
            r_cnt <= r_cnt - COUNT_W'(1);
        end
    end

    // Fill pointer for the reset sweep and mark-all; it restarts after the last frame.
    assign w_fill_last = (r_fill == AW'(MAX_FRAMES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.fill_next) begin
            r_fill <= w_fill_last ? '0 : r_fill + AW'(1);
        end
    end

    // Bitmap memory, one frame per entry.
    assign w_we    = i_cmd.wr_set | i_cmd.wr_clr | i_cmd.wr_fill;
    assign w_waddr = i_cmd.wr_fill ? r_fill : r_cur[AW-1:0];
    assign w_wdata = ~i_cmd.wr_clr;

    bfa_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Status back to the controller.
    assign o_stat.req       = r_req;
    assign o_stat.in_range  = (r_req == REQ_ALLOC) ? (33'(r_cur) < 33'(w_alim))
                                                   : (33'(r_cur) < 33'(w_lim));
    assign o_stat.more      = (r_left != '0);
    assign o_stat.bit_val   = w_rdata;
    assign o_stat.fill_done = w_fill_last;

    // Result register.
    assign w_faddr = 64'(r_cur) << FRAME_SHIFT;
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_fa  <= i_cmd.found ? w_faddr[26:0] : 27'd0;
            r_oom <= i_cmd.oom;
        end
    end

    assign w_used  = 64'(r_cnt) << FRAME_SHIFT;
    assign w_free  = (w_cnt_ext < w_lim) ? (64'(w_lim - w_cnt_ext) << FRAME_SHIFT) : 64'd0;
    assign w_total = 64'(w_lim) << FRAME_SHIFT;

    assign o_frame_address = r_fa;
    assign o_oom           = r_oom;
    assign o_used          = w_used[27:0];
    assign o_free          = w_free[27:0];
    assign o_total         = w_total[27:0];

`ifndef SYNTH
    // Allocation only hands out frames below the aligned limit.
    a_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.found |-> 33'(r_cur) < 33'(w_alim))
        else $error("allocation beyond limit");
    // Walk writes stay below the tracked count.
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_set || i_cmd.wr_clr) |-> 33'(r_cur) < 33'(w_lim))
        else $error("write beyond tracked frames");
    // Out of memory and a found frame exclude each other.
    a_oom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.found && i_cmd.oom))
        else $error("found and oom together");
`endif

endmodule

[sv/bitmap_frame_allocator_top.sv]
// Bitmap frame allocator, first fit, one used bit per frame.
// Requests arrive on the s_axis channel; each accepted word yields exactly one
// result word on m_axis. The register frames_in_use is written through
// i_cfg_we/i_cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. Each request walks the bitmap
// memory one frame per pass, through the states read, wait and act. An
// allocate scans from frame 0 up to the first clear frame below the aligned
// limit and reports out of memory when none is clear; a free inside the
// tracked range acts on one frame; release and reserve walk their frames in
// turn; mark-all sweeps every frame; a request with nothing to walk, or of an
// unknown type, goes straight to its result word. One request is handled at
// a time; s_axis_tready is high only when idle, and the next request is taken
// the cycle after the result word is taken. After reset the block sweeps the
// bitmap to all used before it takes its first request; configuration writes
// are taken as ever. When the receiver stalls the result word holds on m_axis
// until taken, and no new request is accepted meanwhile.
module bitmap_frame_allocator_top import bfa_pkg::*; #(
    parameter int MAX_FRAMES  = 32768,
    parameter int FRAME_SHIFT = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] byte_address, [63:32] byte_length
    input  logic [63:0]  s_axis_tdata,
    // [2:0] req_type
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [26:0] frame_address, [27] out_of_memory, [55:28] used_bytes,
    // [83:56] free_bytes, [111:84] total_bytes
    output logic [111:0] m_axis_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic [26:0] w_fa;
    logic        w_oom;
    logic [27:0] w_used, w_free, w_total;

    bfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    bfa_dp #(.MAX_FRAMES(MAX_FRAMES), .FRAME_SHIFT(FRAME_SHIFT)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_wdata),
        .i_req           (s_axis_tuser),
        .i_addr          (s_axis_tdata[31:0]),
        .i_len           (s_axis_tdata[63:32]),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_frame_address (w_fa),
        .o_oom           (w_oom),
        .o_used          (w_used),
        .o_free          (w_free),
        .o_total         (w_total)
    );

    assign m_axis_tdata = {w_total, w_free, w_used, w_oom, w_fa};

endmodule

[tb/bitmap_frame_allocator_top_test.sv]
module bitmap_frame_allocator_top_test import bfa_pkg::*;;

    localparam int NUM_FRAMES   = 32768;
    localparam int PAGE_SHIFT   = 12;
    localparam int RANDOM_WORDS = 1750;
    localparam int PHASES       = 12;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int LONG_HOLD    = 3000;

    // One result word, laid out as on m_axis_tdata (total bytes in the top bits).
    typedef struct packed {
        logic [27:0] total_bytes;
        logic [27:0] free_bytes;
        logic [27:0] used_bytes;
        logic        out_of_memory;
        logic [26:0] frame_address;
    } t_alloc_result;

    // A row of the directed table: optional register write, request, optional fixed result.
    typedef struct {
        bit            cfg_wr;
        logic [15:0]   cfg_val;
        logic [2:0]    req;
        logic [31:0]   addr;
        logic [31:0]   len;
        bit            fixed;
        t_alloc_result want;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;

    // Shadow copy of the frame bitmap, used count and frame register.
    bit            shadow_map [NUM_FRAMES];
    int            shadow_used;
    int            shadow_frames_reg;
    t_alloc_result pending_results [$];
    int            error_count;
    int            cycle_count;
    int            burst_left;
    int            markall_budget;
    bit            hold_request;
    int            hold_left;
    int            ready_mode;
    int            mode_left;
    t_dir_row      dir_rows [24];

    bitmap_frame_allocator_top #(
        .MAX_FRAMES  (NUM_FRAMES),
        .FRAME_SHIFT (PAGE_SHIFT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock, period 4.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Applies one request to the shadow state and returns the word it should produce.
    function automatic t_alloc_result serve_request(logic [2:0] req, logic [31:0] addr,
                                                    logic [31:0] len);
        int            lim;
        int            start;
        int            nframes;
        int            f;
        bit            found;
        t_alloc_result r;
        lim   = (shadow_frames_reg < NUM_FRAMES) ? shadow_frames_reg : NUM_FRAMES;
        start = int'(addr >> PAGE_SHIFT);
        r     = '0;
        case (req)
            REQ_ALLOC: begin
                found = 1'b0;
                for (f = 0; f < (lim / 8) * 8 && !found; f++) begin
                    if (!shadow_map[f]) begin
                        shadow_map[f] = 1'b1;
                        if (shadow_used < 65535) shadow_used++;
                        r.frame_address = 27'(f << PAGE_SHIFT);
                        found = 1'b1;
                    end
                end
                r.out_of_memory = !found;
            end
            REQ_FREE: begin
                if (start < lim && shadow_map[start]) begin
                    shadow_map[start] = 1'b0;
                    if (shadow_used > 0) shadow_used--;
                end
            end
            REQ_RELEASE: begin
                // Every frame in range is counted down, even when already clear.
                nframes = int'(len >> PAGE_SHIFT);
                for (f = start; f < start + nframes && f < lim; f++) begin
                    shadow_map[f] = 1'b0;
                    if (shadow_used > 0) shadow_used--;
                end
            end
            REQ_RESERVE: begin
                // Size rounds up, and only newly set frames are counted.
                nframes = int'((longint'(len) + (64'd1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT);
                for (f = start; f < start + nframes && f < lim; f++) begin
                    if (!shadow_map[f]) begin
                        shadow_map[f] = 1'b1;
                        if (shadow_used < 65535) shadow_used++;
                    end
                end
            end
            REQ_MARKALL: begin
                shadow_map  = '{default: 1'b1};
                shadow_used = lim;
            end
            default: begin
            end
        endcase
        r.used_bytes  = 28'(longint'(shadow_used) << PAGE_SHIFT);
        r.free_bytes  = (shadow_used < lim) ? 28'(longint'(lim - shadow_used) << PAGE_SHIFT)
                                            : 28'd0;
        r.total_bytes = 28'(longint'(lim) << PAGE_SHIFT);
        return r;
    endfunction

    // Offers one word and records its expected result once it is taken.
    task automatic offer_word(input logic [2:0] req, input logic [31:0] addr,
                              input logic [31:0] len, input bit fixed,
                              input t_alloc_result want);
        t_alloc_result predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {len, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = serve_request(req, addr, len);
        pending_results.push_back(fixed ? want : predicted);
        // Bursts of random length separated by random gaps.
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write while the block is idle.
    task automatic write_frames_reg(input logic [15:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_frames_reg = int'(value);
    endtask

    // Random request, mostly aimed at frames inside the tracked range.
    task automatic make_request(output logic [2:0] req, output logic [31:0] addr,
                                output logic [31:0] len);
        int k;
        int lim;
        lim = (shadow_frames_reg < NUM_FRAMES) ? shadow_frames_reg : NUM_FRAMES;
        k   = $urandom_range(0, 99);
        if (k < 35)      req = REQ_ALLOC;
        else if (k < 55) req = REQ_FREE;
        else if (k < 72) req = REQ_RELEASE;
        else if (k < 89) req = REQ_RESERVE;
        else if (k < 96) req = 3'($urandom_range(5, 7));
        else if (markall_budget > 0) begin
            req = REQ_MARKALL;
            markall_budget--;
        end else begin
            req = REQ_ALLOC;
        end
        if ($urandom_range(0, 9) == 0) addr = $urandom;
        else addr = {20'($urandom_range(0, lim + 3)), 12'($urandom_range(0, 4095))};
        if ($urandom_range(0, 9) == 0) len = $urandom;
        else len = 32'($urandom_range(0, 6) * 4096)
                 + (($urandom_range(0, 1) == 1) ? 32'($urandom_range(0, 4095)) : 32'd0);
    endtask

    // Receiver: stall pattern of its own, long hold-off on request, and the checks.
    always @(posedge i_clk) begin
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            ready_mode    <= 0;
            mode_left     <= 0;
        end else begin
            if (hold_request && hold_left == 0) begin
                hold_left <= LONG_HOLD;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(50, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (hold_left > 1 || (hold_request && hold_left == 0)) begin
                m_axis_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.frame_address !== want.frame_address) begin
                        $display("%0t: frame_address expected %h actual %h",
                                 $time, want.frame_address, got.frame_address);
                        error_count++;
                    end
                    if (got.out_of_memory !== want.out_of_memory) begin
                        $display("%0t: out_of_memory expected %b actual %b",
                                 $time, want.out_of_memory, got.out_of_memory);
                        error_count++;
                    end
                    if (got.used_bytes !== want.used_bytes) begin
                        $display("%0t: used_bytes expected %h actual %h",
                                 $time, want.used_bytes, got.used_bytes);
                        error_count++;
                    end
                    if (got.free_bytes !== want.free_bytes) begin
                        $display("%0t: free_bytes expected %h actual %h",
                                 $time, want.free_bytes, got.free_bytes);
                        error_count++;
                    end
                    if (got.total_bytes !== want.total_bytes) begin
                        $display("%0t: total_bytes expected %h actual %h",
                                 $time, want.total_bytes, got.total_bytes);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin
        logic [2:0]  req;
        logic [31:0] addr;
        logic [31:0] len;
        int          per_phase;
        logic [15:0] frames_val;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        hold_request  = 1'b0;
        burst_left    = 1;
        markall_budget = 6;
        shadow_map        = '{default: 1'b1};
        shadow_frames_reg = 32768;
        shadow_used       = 32768;

        dir_rows = '{
            '{0, 16'd0,     REQ_ALLOC,   32'h0,        32'h0,        1,
              '{28'h8000000, 28'h0, 28'h8000000, 1'b1, 27'h0}},
            '{0, 16'd0,     3'd5,        32'hFFFFFFFF, 32'hFFFFFFFF, 1,
              '{28'h8000000, 28'h0, 28'h8000000, 1'b0, 27'h0}},
            '{0, 16'd0,     3'd7,        32'h0,        32'h0,        1,
              '{28'h8000000, 28'h0, 28'h8000000, 1'b0, 27'h0}},
            '{0, 16'd0,     REQ_RELEASE, 32'h0,        32'h3000,     0, '0},
            '{0, 16'd0,     REQ_ALLOC,   32'h0,        32'h0,        0, '0},
            '{0, 16'd0,     REQ_FREE,    32'h1000,     32'h0,        0, '0},
            '{0, 16'd0,     REQ_FREE,    32'h1000,     32'h0,        0, '0},
            '{0, 16'd0,     REQ_RESERVE, 32'h1001,     32'h1,        0, '0},
            '{0, 16'd0,     REQ_RELEASE, 32'h7FFF000,  32'h2000,     0, '0},
            '{0, 16'd0,     REQ_FREE,    32'hFFFFFFFF, 32'h0,        0, '0},
            '{0, 16'd0,     REQ_RESERVE, 32'hFFFFF000, 32'hFFFFFFFF, 0, '0},
            '{0, 16'd0,     REQ_MARKALL, 32'h0,        32'h0,        1,
              '{28'h8000000, 28'h0, 28'h8000000, 1'b0, 27'h0}},
            // Used count above the tracked size: free bytes read zero.
            '{1, 16'd16,    REQ_ALLOC,   32'h0,        32'h0,        1,
              '{28'h10000, 28'h0, 28'h8000000, 1'b1, 27'h0}},
            '{0, 16'd0,     REQ_RELEASE, 32'h0,        32'hFFFFFFFF, 0, '0},
            '{0, 16'd0,     REQ_ALLOC,   32'h0,        32'h0,        0, '0},
            '{0, 16'd0,     REQ_RESERVE, 32'h0,        32'hFFFFFFFF, 0, '0},
            '{0, 16'd0,     REQ_MARKALL, 32'h0,        32'h0,        1,
              '{28'h10000, 28'h0, 28'h10000, 1'b0, 27'h0}},
            '{0, 16'd0,     REQ_RELEASE, 32'h0,        32'hFFFFFFFF, 1,
              '{28'h10000, 28'h10000, 28'h0, 1'b0, 27'h0}},
            // Releasing clear frames leaves the count pinned at zero.
            '{0, 16'd0,     REQ_RELEASE, 32'h0,        32'hFFFFFFFF, 1,
              '{28'h10000, 28'h10000, 28'h0, 1'b0, 27'h0}},
            '{1, 16'd0,     REQ_ALLOC,   32'h0,        32'h0,        1,
              '{28'h0, 28'h0, 28'h0, 1'b1, 27'h0}},
            '{0, 16'd0,     REQ_MARKALL, 32'h0,        32'h0,        1,
              '{28'h0, 28'h0, 28'h0, 1'b0, 27'h0}},
            // Register above the bitmap size is clipped to it.
            '{1, 16'hFFFF,  REQ_ALLOC,   32'h0,        32'h0,        1,
              '{28'h8000000, 28'h8000000, 28'h0, 1'b1, 27'h0}},
            '{0, 16'd0,     REQ_RELEASE, 32'h0,        32'h8000,     0, '0},
            '{0, 16'd0,     REQ_ALLOC,   32'h0,        32'h0,        0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_wr) write_frames_reg(dir_rows[i].cfg_val);
            offer_word(dir_rows[i].req, dir_rows[i].addr, dir_rows[i].len,
                       dir_rows[i].fixed, dir_rows[i].want);
        end

        // Random phases, each with its own tracked size; all kept small for speed.
        per_phase = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       frames_val = 16'd64;
                1:       frames_val = 16'd8;
                2:       frames_val = 16'd1;
                default: frames_val = 16'($urandom_range(2, 256));
            endcase
            write_frames_reg(frames_val);
            if (p == 3) hold_request <= 1'b1;
            for (int n = 0; n < per_phase; n++) begin
                if (p == 3 && n == 20) hold_request <= 1'b0;
                // Once, midway through phase 5, the sender pauses until everything is back.
                if (p == 5 && n == per_phase / 2) drain_results();
                make_request(req, addr, len);
                offer_word(req, addr, len, 1'b0, '0);
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bfa_ctrl.sv
sv/bfa_dp.sv
sv/bitmap_frame_allocator_top.sv
tb/bitmap_frame_allocator_top_test.sv
